@@ hw/rtl/nfha_pkg.sv @@
package nfha_pkg;

    // Table geometry
    localparam int SLOTS    = 1024;
    localparam int HANDLE_W = 11;
    localparam int ID_W     = 32;
    localparam int SLOT_W   = $clog2(SLOTS);

    // Used map is kept as rows of WORD_W bits, read one row at a time
    localparam int WORD_W = (SLOTS < 32) ? (2 ** $clog2(SLOTS)) : 32;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_HANDLE    = 2'd1,
        ST_BACKEND_FAIL = 2'd2,
        ST_INVALID      = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PUSH
    } fsm_t;

endpackage

@@ hw/rtl/nfha_ram.sv @@
module nfha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/next_fit_handle_allocator_unit.sv @@
// Flow: the accepting edge issues the first used-map read (and the object read for a
//   free); S_EVAL then settles a free, or an allocate that finds a slot in the probe's
//   own row; each further row takes one S_READ (synchronous read) and one S_EVAL.
// A new transaction is taken only in S_IDLE, after the last result has left S_PUSH for
//   the output register; a result held at the output stalls the input.
// Reset: asynchronous, active low; clears the probe, the row valid bits (all slots free).
module next_fit_handle_allocator_unit
    import nfha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [HANDLE_W-1:0] handle_in,
    input  logic                backend_ok,
    input  logic [ID_W-1:0]     object_id,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [ID_W-1:0]     freed_id,
    output logic [1:0]          status
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    fsm_t                state_reg, state_next;

    // Transaction being worked on
    logic                cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                ok_reg;
    logic [ID_W-1:0]     id_reg;

    // Search control
    logic [SLOT_W-1:0]   probe_reg, probe_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // One valid bit per used-map row: a row never written reads as all free
    logic [ROWS-1:0]     row_valid_reg, row_valid_next;

    // Result staging, then the output register
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    status_t             res_status_reg, res_status_next;

    logic                out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic [ID_W-1:0]     freed_id_reg;
    status_t             status_reg;

    // ------------------------------------------------------------------
    // Memories: used map (rows of bits) and object ids (one per slot)
    // ------------------------------------------------------------------
    logic                bm_we, bm_re;
    logic [ROW_W-1:0]    bm_raddr;
    logic [WORD_W-1:0]   bm_wdata, bm_rdata;

    logic                obj_we, obj_re;
    logic [SLOT_W-1:0]   obj_waddr, obj_raddr;
    logic [ID_W-1:0]     obj_rdata;

    nfha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_used_map (
        .clk   (clk),
        .we    (bm_we),
        .waddr (row_reg),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    nfha_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_objects (
        .clk   (clk),
        .we    (obj_we),
        .waddr (obj_waddr),
        .wdata (id_reg),
        .re    (obj_re),
        .raddr (obj_raddr),
        .rdata (obj_rdata)
    );

    // ------------------------------------------------------------------
    // Address generation at accept
    // ------------------------------------------------------------------
    logic                accept;
    logic [HANDLE_W-1:0] handle_in_dec;
    logic [ROW_W-1:0]    start_row;
    logic [ROW_W-1:0]    free_row_in;

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign handle_in_dec = handle_in - HANDLE_W'(1);
    assign start_row     = ROW_W'(probe_reg >> BIT_W);
    assign free_row_in   = ROW_W'(handle_in_dec >> BIT_W);

    // ------------------------------------------------------------------
    // Row evaluation
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]   word;
    logic [BIT_W-1:0]    probe_bit;
    logic [WORD_W-1:0]   cand;
    logic                hit;
    logic [BIT_W-1:0]    hit_bit;
    logic [SLOT_W-1:0]   hit_slot;
    logic [SLOT_W:0]     bit_slot;
    logic                first_pass, last_pass;

    logic [HANDLE_W-1:0] handle_dec;
    logic [BIT_W-1:0]    free_bit;
    logic                handle_ok;
    logic                slot_in_use;
    logic [WORD_W-1:0]   free_mask;

    // A row that was never written holds only free slots
    assign word       = row_valid_reg[row_reg] ? bm_rdata : '0;
    assign probe_bit  = probe_reg[BIT_W-1:0];
    assign first_pass = (cnt_reg == CNT_W'(0));
    assign last_pass  = (cnt_reg == CNT_W'(ROWS));

    // Candidate bits: free, inside the table, and in this pass's window.
    // First visit to the probe row takes bits above the probe, the final
    // wrap-around visit takes bits below it; the probe slot is never a candidate.
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            bit_slot = ((SLOT_W + 1)'(row_reg) << BIT_W) | (SLOT_W + 1)'(i);
            cand[i]  = !word[i] && (bit_slot < (SLOT_W + 1)'(SLOTS));
            if (first_pass)
            begin
                cand[i] = cand[i] && (BIT_W'(i) > probe_bit);
            end
            else if (last_pass)
            begin
                cand[i] = cand[i] && (BIT_W'(i) < probe_bit);
            end
        end
    end

    // Lowest candidate wins
    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(i);
            end
        end
    end

    assign hit_slot = (SLOT_W'(row_reg) << BIT_W) | SLOT_W'(hit_bit);

    assign handle_dec  = handle_reg - HANDLE_W'(1);
    assign free_bit    = handle_dec[BIT_W-1:0];
    assign handle_ok   = (handle_reg != '0) && (handle_reg <= HANDLE_W'(SLOTS));
    assign slot_in_use = word[free_bit];
    assign free_mask   = WORD_W'(1) << free_bit;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        probe_next      = probe_reg;
        row_next        = row_reg;
        cnt_next        = cnt_reg;
        row_valid_next  = row_valid_reg;
        res_handle_next = res_handle_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;

        bm_re     = 1'b0;
        bm_raddr  = row_reg;
        bm_we     = 1'b0;
        bm_wdata  = word;
        obj_re    = 1'b0;
        obj_raddr = SLOT_W'(handle_in_dec);
        obj_we    = 1'b0;
        obj_waddr = hit_slot;

        // Drop the result once taken
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Issue the first read with the transaction
                    bm_re    = 1'b1;
                    bm_raddr = (cmd == CMD_FREE) ? free_row_in : start_row;
                    obj_re   = (cmd == CMD_FREE);
                    row_next = bm_raddr;
                    cnt_next = '0;
                    state_next = S_EVAL;
                end
            end

            S_READ:
            begin
                bm_re      = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (hit)
                    begin
                        probe_next = hit_slot;
                        if (ok_reg)
                        begin
                            bm_we    = 1'b1;
                            bm_wdata = word | (WORD_W'(1) << hit_bit);
                            obj_we   = 1'b1;
                            row_valid_next[row_reg] = 1'b1;
                            res_handle_next = HANDLE_W'(hit_slot) + HANDLE_W'(1);
                            res_status_next = ST_OK;
                        end
                        else
                        begin
                            res_handle_next = '0;
                            res_status_next = ST_BACKEND_FAIL;
                        end
                        res_id_next = '0;
                        state_next  = S_PUSH;
                    end
                    else if (last_pass)
                    begin
                        res_handle_next = '0;
                        res_id_next     = '0;
                        res_status_next = ST_NO_HANDLE;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        // Advance to the next row, wrapping at the table end
                        cnt_next   = cnt_reg + CNT_W'(1);
                        row_next   = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + ROW_W'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    res_handle_next = handle_reg;
                    if (handle_ok && slot_in_use)
                    begin
                        bm_we           = 1'b1;
                        bm_wdata        = word & ~free_mask;
                        res_id_next     = obj_rdata;
                        res_status_next = ST_OK;
                    end
                    else
                    begin
                        res_id_next     = '0;
                        res_status_next = ST_INVALID;
                    end
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // Hold until the output register has room
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            probe_reg     <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            probe_reg     <= probe_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            handle_reg <= handle_in;
            ok_reg     <= backend_ok;
            id_reg     <= object_id;
        end
        row_reg        <= row_next;
        cnt_reg        <= cnt_next;
        res_handle_reg <= res_handle_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_PUSH) && (!out_valid_reg || out_ready))
        begin
            handle_out_reg <= res_handle_reg;
            freed_id_reg   <= res_id_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign handle_out = handle_out_reg;
    assign freed_id   = freed_id_reg;
    assign status     = status_reg;

endmodule

@@ bench/handle_ledger_pkg.sv @@
package handle_ledger_pkg;

    import nfha_pkg::*;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
        status_t             status;
    } handle_reply_t;

    // Mirror of the slot table plus the replies still owed by the block
    class handle_ledger;
        bit                  slot_busy[SLOTS];
        logic [ID_W-1:0]     slot_id[SLOTS];
        int unsigned         probe;
        int                  busy_count;
        handle_reply_t       replies_due[$];
        int                  mismatches;
        int                  replies_checked;
        int                  status_seen[4];

        function new();
            foreach (slot_busy[i]) begin
                slot_busy[i] = 1'b0;
                slot_id[i]   = '0;
            end
            probe           = 0;
            busy_count      = 0;
            mismatches      = 0;
            replies_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Apply one accepted transaction to the table and queue its reply
        function void note_request(cmd_t c, logic [HANDLE_W-1:0] h, logic ok,
                                   logic [ID_W-1:0] id);
            handle_reply_t r;
            int unsigned   idx;
            bit            found;
            r     = '0;
            idx   = 0;
            found = 1'b0;
            if (c == CMD_ALLOC) begin
                // next fit: scan from just past the probe, wrap, never the probe
                for (int k = 1; k < SLOTS && !found; k++) begin
                    idx = (probe + k) % SLOTS;
                    if (!slot_busy[idx])
                        found = 1'b1;
                end
                if (!found) begin
                    r.status = ST_NO_HANDLE;
                end
                else begin
                    probe = idx;
                    if (!ok) begin
                        r.status = ST_BACKEND_FAIL;
                    end
                    else begin
                        slot_busy[idx] = 1'b1;
                        slot_id[idx]   = id;
                        busy_count++;
                        r.handle = HANDLE_W'(idx + 1);
                        r.status = ST_OK;
                    end
                end
            end
            else begin
                r.handle = h;
                if (h == 0 || h > SLOTS || !slot_busy[h - 1]) begin
                    r.status = ST_INVALID;
                end
                else begin
                    r.id             = slot_id[h - 1];
                    slot_busy[h - 1] = 1'b0;
                    slot_id[h - 1]   = '0;
                    busy_count--;
                    r.status = ST_OK;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [HANDLE_W-1:0] h, logic [ID_W-1:0] id,
                                  logic [1:0] st);
            handle_reply_t want;
            replies_checked++;
            if (!$isunknown(st))
                status_seen[st]++;
            if (replies_due.size() == 0) begin
                $error("reply with no transaction pending: handle_out %0d status %0d",
                       h, st);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (h !== want.handle) begin
                $error("handle_out: expected %0d, got %0d", want.handle, h);
                mismatches++;
            end
            if (id !== want.id) begin
                $error("freed_id: expected 0x%08h, got 0x%08h", want.id, id);
                mismatches++;
            end
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                mismatches++;
            end
        endfunction

        // Any handle currently in use, or 0 when the table is empty
        function int pick_busy_handle();
            int unsigned start;
            int unsigned idx;
            if (busy_count == 0)
                return 0;
            start = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++) begin
                idx = (start + k) % SLOTS;
                if (slot_busy[idx])
                    return idx + 1;
            end
            return 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

endpackage

@@ bench/testbench.sv @@
module testbench;

    import nfha_pkg::*;
    import handle_ledger_pkg::*;

    // Limit for the whole run, set with ample margin
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SQUEEZE_LEN  = 300;
    localparam int RANDOM_ITEMS = 360;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                cmd        = 1'b0;
    logic [HANDLE_W-1:0] handle_in  = '0;
    logic                backend_ok = 1'b0;
    logic [ID_W-1:0]     object_id  = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [HANDLE_W-1:0] handle_out;
    logic [ID_W-1:0]     freed_id;
    logic [1:0]          status;

    handle_ledger ledger = new();

    // When set, neither side adds random idle gaps (a squeeze hold still applies)
    bit steady = 1'b0;

    // Receiver hold-off request: main bumps squeeze_req, receiver catches up
    int squeeze_req  = 0;
    int squeeze_seen = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    next_fit_handle_allocator_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .handle_in  (handle_in),
        .backend_ok (backend_ok),
        .object_id  (object_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .handle_out (handle_out),
        .freed_id   (freed_id),
        .status     (status)
    );

    always #4 clk = ~clk;

    // Gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one transaction, hold it until accepted, then record it.
    // Valid is only dropped when a gap follows, so back-to-back items keep it high.
    task automatic send_request(input cmd_t c, input logic [HANDLE_W-1:0] h,
                                input logic ok, input logic [ID_W-1:0] id);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        handle_in  <= h;
        backend_ok <= ok;
        object_id  <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ledger.note_request(c, h, ok, id);
    endtask

    // Allocate; the handle field is ignored by the block, so fill it with noise
    task automatic alloc_req(input logic ok, input logic [ID_W-1:0] id);
        send_request(CMD_ALLOC, HANDLE_W'($urandom_range(0, 2047)), ok, id);
    endtask

    // Free; backend_ok and object_id are ignored on a free, so randomize them
    task automatic free_req(input logic [HANDLE_W-1:0] h);
        send_request(CMD_FREE, h, 1'($urandom), $urandom());
    endtask

    // Free a handle known to be in use, or allocate if the table is empty
    task automatic free_some_busy();
        int h;
        h = ledger.pick_busy_handle();
        if (h == 0)
            alloc_req(1'b1, $urandom());
        else
            free_req(HANDLE_W'(h));
    endtask

    // One random transaction: mostly well-formed allocate/free traffic,
    // some backend failures and some stray handles
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            alloc_req(1'b1, $urandom());
        else if (r < 45)
            alloc_req(1'b0, $urandom());
        else if (r < 85)
            free_some_busy();
        else if (r < 93)
            free_req(HANDLE_W'($urandom_range(0, 2047)));
        else
            free_req(HANDLE_W'($urandom_range(1, SLOTS)));
    endtask

    // Receiver: check every accepted result, then pick out_ready for the next cycle
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                ledger.check_reply(handle_out, freed_id, status);
            if (squeeze_seen != squeeze_req) begin
                squeeze_seen = squeeze_req;
                hold_left    = SQUEEZE_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 9) == 0) begin
                hold_left = pick_gap();
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if the block stops making progress
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, ledger.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        // Hold reset, then release it on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: invalid handles at both ends of the range and past it
        free_req(HANDLE_W'(0));
        free_req(HANDLE_W'(1));
        free_req(HANDLE_W'(SLOTS));
        free_req(HANDLE_W'(SLOTS + 1));
        free_req(HANDLE_W'(2047));

        // Probe sits on slot 0 after reset, so the first allocate gets slot 1
        alloc_req(1'b1, 32'h0000_0000);
        // Backend failure moves the probe but leaves the slot free
        alloc_req(1'b0, 32'hFFFF_FFFF);
        alloc_req(1'b1, 32'hFFFF_FFFF);
        free_req(HANDLE_W'(4));
        // Freeing the same handle again hits an unused slot
        free_req(HANDLE_W'(4));
        free_req(HANDLE_W'(2));
        free_req(HANDLE_W'(3));
        alloc_req(1'b1, 32'hA5A5_5A5A);
        alloc_req(1'b1, 32'h5A5A_A5A5);
        free_req(HANDLE_W'(1));

        // Random traffic; midway, stall the receiver while the sender keeps pushing
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 180) begin
                steady      = 1'b1;
                squeeze_req <= squeeze_req + 1;
            end
            if (i == 220)
                steady = 1'b0;
            if (i == 290)
                steady = 1'b1;
            if (i == 330)
                steady = 1'b0;
            random_item();
        end

        // Drain part of the table with a mix of traffic
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 3) == 0)
                random_item();
            else
                free_some_busy();
        end

        // Stop offering and wait for the last replies, then for the block's
        // longest search to be sure nothing stray comes out
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (2 * ROWS + 8) @(posedge clk);

        $display("Checked %0d replies: %0d ok, %0d out of handles, %0d backend failed,",
                 ledger.replies_checked, ledger.status_seen[ST_OK],
                 ledger.status_seen[ST_NO_HANDLE], ledger.status_seen[ST_BACKEND_FAIL]);
        $display("%0d invalid handles; mixed gaps, back-to-back bursts and a long output stall.",
                 ledger.status_seen[ST_INVALID]);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
